// File: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the battery power statistics block.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CURRENT_GAIN    = 3'd0,
		REG_INVERT_CURRENT  = 3'd1,
		REG_MIN_VALID_BUS   = 3'd2,
		REG_ALPHA_FAST      = 3'd3,
		REG_ALPHA_SLOW      = 3'd4,
		REG_MAX_INTERVAL_MS = 3'd5
	} cfg_reg_t;

	// datapath operations, one per controller step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CURRENT,
		OP_POWER,
		OP_EMA_CF,
		OP_EMA_CS,
		OP_EMA_PF,
		OP_EMA_PS,
		OP_INTEGRATE,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic seed;
		logic update;
	} bps_cmd_t;

	typedef struct packed {
		logic valid_sample;
		logic seeded;
	} bps_status_t;

endpackage

// File: hw/rtl/battery_power_statistics.sv
// ----------------------------------------------------------------------------
// battery_power_statistics
// Power monitor with exponential averages and saturating charge/energy totals.
// ----------------------------------------------------------------------------
// One request is handled at a time: a sequencer walks it through eight steps of
// a shared datapath (current, power, four average updates, integration,
// commit), then presents the result until it is taken. The result appears
// once the commit step is done, and no new request is accepted until it is
// taken. The block is ready for the next request the cycle after its result is
// taken. Configuration writes are always ready.
module battery_power_statistics import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] shunt_sample,
	input  logic [14:0]        bus_raw,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [46:0] power_signed,
	output logic [30:0]        avg_current_fast,
	output logic [30:0]        avg_current_slow,
	output logic [45:0]        avg_power_fast,
	output logic [45:0]        avg_power_slow,
	output logic [14:0]        min_voltage,
	output logic [14:0]        max_voltage,
	output logic [30:0]        max_current,
	output logic [45:0]        max_power,
	output logic [63:0]        charge_used,
	output logic [63:0]        energy_used,
	output logic               stats_valid,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	bps_cmd_t    cmd;
	bps_status_t status;
	logic [15:0] current_gain;
	logic        invert_current;
	logic [14:0] min_valid_bus;
	logic [16:0] alpha_fast, alpha_slow;
	logic [31:0] max_interval_ms;

	bps_cfg u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.current_gain, .invert_current, .min_valid_bus, .alpha_fast,
		.alpha_slow, .max_interval_ms
	);

	bps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .status
	);

	bps_datapath u_dp (
		.clk, .arst_n, .cmd, .status, .shunt_sample, .bus_raw, .now_ms,
		.current_gain, .invert_current, .min_valid_bus, .alpha_fast,
		.alpha_slow, .max_interval_ms, .power_signed, .avg_current_fast,
		.avg_current_slow, .avg_power_fast, .avg_power_slow, .min_voltage,
		.max_voltage, .max_current, .max_power, .charge_used, .energy_used,
		.stats_valid
	);

endmodule

// File: hw/rtl/bps_datapath.sv
// ----------------------------------------------------------------------------
// bps_datapath
// Sample registers, the multiplier paths and the statistics state.
// ----------------------------------------------------------------------------
module bps_datapath import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  bps_cmd_t           cmd,
	output bps_status_t        status,
	input  logic signed [15:0] shunt_sample,
	input  logic [14:0]        bus_raw,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        current_gain,
	input  logic               invert_current,
	input  logic [14:0]        min_valid_bus,
	input  logic [16:0]        alpha_fast,
	input  logic [16:0]        alpha_slow,
	input  logic [31:0]        max_interval_ms,
	output logic signed [46:0] power_signed,
	output logic [30:0]        avg_current_fast,
	output logic [30:0]        avg_current_slow,
	output logic [45:0]        avg_power_fast,
	output logic [45:0]        avg_power_slow,
	output logic [14:0]        min_voltage,
	output logic [14:0]        max_voltage,
	output logic [30:0]        max_current,
	output logic [45:0]        max_power,
	output logic [63:0]        charge_used,
	output logic [63:0]        energy_used,
	output logic               stats_valid
);

	logic signed [15:0] shunt_q;
	logic [14:0]        bus_q;
	logic [31:0]        now_q;
	logic [30:0]        mag_q;
	logic               neg_q;
	logic [45:0]        pwr_q;
	logic               seeded_q;
	logic [47:0]        cf_q, cs_q;
	logic [61:0]        pf_q, ps_q;
	logic [14:0]        lo_q, hi_q;
	logic [30:0]        pk_i_q;
	logic [45:0]        pk_p_q;
	logic [63:0]        chg_q, eng_q;
	logic [31:0]        last_q;

	// magnitude of shunt * gain, 16 x 16
	logic [15:0] shunt_abs;
	logic [31:0] cur_prod;
	logic        cur_neg;
	assign shunt_abs = shunt_q[15] ? 16'(-shunt_q) : shunt_q;
	assign cur_prod  = shunt_abs * current_gain;
	assign cur_neg   = shunt_q[15] ^ invert_current;

	// ema: delta = a*(diff>>16) + ((a*(diff&ffff))>>16)
	logic [16:0] alpha_sel, a_clip;
	logic [61:0] ema_avg, ema_tgt, ema_diff, ema_new, ema_delta;
	logic        ema_up;
	logic [62:0] prod_hi;
	logic [32:0] prod_lo;
	always_comb begin
		case (cmd.op)
			OP_EMA_CF: begin alpha_sel = alpha_fast; ema_avg = {14'd0, cf_q}; end
			OP_EMA_CS: begin alpha_sel = alpha_slow; ema_avg = {14'd0, cs_q}; end
			OP_EMA_PF: begin alpha_sel = alpha_fast; ema_avg = pf_q; end
			OP_EMA_PS: begin alpha_sel = alpha_slow; ema_avg = ps_q; end
			default:   begin alpha_sel = alpha_fast; ema_avg = pf_q; end
		endcase
		if (cmd.op == OP_EMA_CF || cmd.op == OP_EMA_CS)
			ema_tgt = {15'd0, mag_q, 16'd0};
		else
			ema_tgt = {pwr_q, 16'd0};
		a_clip   = alpha_sel[16] ? 17'h10000 : alpha_sel;
		ema_up   = ema_tgt >= ema_avg;
		ema_diff = ema_up ? ema_tgt - ema_avg : ema_avg - ema_tgt;
		prod_hi  = 63'(a_clip) * 63'(ema_diff[61:16]);
		prod_lo  = 33'(a_clip) * 33'(ema_diff[15:0]);
		ema_delta = 62'(prod_hi + 63'(prod_lo[32:16]));
		ema_new  = ema_up ? ema_avg + ema_delta : ema_avg - ema_delta;
	end

	// saturating x*dt, x up to 46 bits, dt 32 bits: split x into two 23-bit halves
	logic [31:0] dt;
	logic        dt_ok;
	logic [54:0] m_lo_s1, m_hi_s1, e_lo_s1, e_hi_s1;
	assign dt    = now_q - last_q;
	assign dt_ok = (dt != 32'd0) && (dt < max_interval_ms);

	function automatic logic [63:0] sat_sum(input logic [54:0] lo, input logic [54:0] hi,
	                                        input logic [63:0] acc);
		logic [78:0] prod;
		logic [64:0] s;
		prod = {hi, 23'd0} + 79'(lo);
		if (prod[78:64] != 15'd0)
			return '1;
		s = {1'b0, acc} + {1'b0, prod[63:0]};
		return s[64] ? '1 : s[63:0];
	endfunction

	assign status.valid_sample = bus_q >= min_valid_bus;
	assign status.seeded       = seeded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shunt_q <= '0; bus_q <= '0; now_q <= '0;
			mag_q <= '0; neg_q <= 1'b0; pwr_q <= '0;
			m_lo_s1 <= '0; m_hi_s1 <= '0; e_lo_s1 <= '0; e_hi_s1 <= '0;
			seeded_q <= 1'b0;
			cf_q <= '0; cs_q <= '0; pf_q <= '0; ps_q <= '0;
			lo_q <= '0; hi_q <= '0; pk_i_q <= '0; pk_p_q <= '0;
			chg_q <= '0; eng_q <= '0; last_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					shunt_q <= shunt_sample;
					bus_q   <= bus_raw;
					now_q   <= now_ms;
				end
				OP_CURRENT: begin
					mag_q <= cur_prod[30:0];
					neg_q <= cur_neg && (cur_prod != 32'd0);
				end
				OP_POWER: begin
					pwr_q <= 46'(bus_q) * 46'(mag_q);
					if (cmd.seed) begin
						cf_q <= {1'b0, mag_q, 16'd0};
						cs_q <= {1'b0, mag_q, 16'd0};
						lo_q <= bus_q;
						hi_q <= bus_q;
						pk_i_q <= mag_q;
					end
				end
				OP_EMA_CF: if (cmd.update) cf_q <= ema_new[47:0];
				OP_EMA_CS: if (cmd.update) cs_q <= ema_new[47:0];
				OP_EMA_PF: begin
					if (cmd.seed) begin
						pf_q <= {pwr_q, 16'd0};
						ps_q <= {pwr_q, 16'd0};
						pk_p_q <= pwr_q;
					end else if (cmd.update) begin
						pf_q <= ema_new;
					end
					m_lo_s1 <= 55'(mag_q[22:0]) * 55'(dt);
					m_hi_s1 <= 55'(mag_q[30:23]) * 55'(dt);
				end
				OP_EMA_PS: begin
					if (cmd.update) ps_q <= ema_new;
					e_lo_s1 <= 55'(pwr_q[22:0]) * 55'(dt);
					e_hi_s1 <= 55'(pwr_q[45:23]) * 55'(dt);
				end
				OP_INTEGRATE: begin
					if (cmd.update) begin
						if (bus_q < lo_q) lo_q <= bus_q;
						if (bus_q > hi_q) hi_q <= bus_q;
						if (mag_q > pk_i_q) pk_i_q <= mag_q;
						if (pwr_q > pk_p_q) pk_p_q <= pwr_q;
						if (dt_ok) begin
							chg_q <= sat_sum(m_lo_s1, m_hi_s1, chg_q);
							eng_q <= sat_sum(e_lo_s1, e_hi_s1, eng_q);
						end
					end
				end
				OP_COMMIT: begin
					if (cmd.seed) seeded_q <= 1'b1;
					if (cmd.seed || cmd.update) last_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	// signed power from the held magnitude and sign
	assign power_signed = neg_q ? -$signed({1'b0, pwr_q}) : $signed({1'b0, pwr_q});

	assign avg_current_fast = cf_q[46:16];
	assign avg_current_slow = cs_q[46:16];
	assign avg_power_fast   = pf_q[61:16];
	assign avg_power_slow   = ps_q[61:16];
	assign min_voltage      = lo_q;
	assign max_voltage      = hi_q;
	assign max_current      = pk_i_q;
	assign max_power        = pk_p_q;
	assign charge_used      = chg_q;
	assign energy_used      = eng_q;
	assign stats_valid      = seeded_q;

endmodule

// File: hw/rtl/bps_ctrl.sv
// ----------------------------------------------------------------------------
// bps_ctrl
// Sequencer: steps one request through the datapath and holds the result.
// ----------------------------------------------------------------------------
module bps_ctrl import bps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output bps_cmd_t    cmd,
	input  bps_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE, S_CUR, S_PWR, S_CF, S_CS, S_PF, S_PS, S_INT, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;
	logic   seed_q, upd_q;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd.seed   = seed_q;
		cmd.update = upd_q;
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_CUR:    cmd.op = OP_CURRENT;
			S_PWR:    cmd.op = OP_POWER;
			S_CF:     cmd.op = OP_EMA_CF;
			S_CS:     cmd.op = OP_EMA_CS;
			S_PF:     cmd.op = OP_EMA_PF;
			S_PS:     cmd.op = OP_EMA_PS;
			S_INT:    cmd.op = OP_INTEGRATE;
			S_COMMIT: cmd.op = OP_COMMIT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seed_q  <= 1'b0;
			upd_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CUR;
				S_CUR: begin
					seed_q  <= status.valid_sample && !status.seeded;
					upd_q   <= status.valid_sample && status.seeded;
					state_q <= S_PWR;
				end
				S_PWR:    state_q <= S_CF;
				S_CF:     state_q <= S_CS;
				S_CS:     state_q <= S_PF;
				S_PF:     state_q <= S_PS;
				S_PS:     state_q <= S_INT;
				S_INT:    state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/bps_cfg.sv
// ----------------------------------------------------------------------------
// bps_cfg
// Configuration register file written through its own valid/ready port.
// ----------------------------------------------------------------------------
module bps_cfg import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data,
	output logic [15:0]        current_gain,
	output logic               invert_current,
	output logic [14:0]        min_valid_bus,
	output logic [16:0]        alpha_fast,
	output logic [16:0]        alpha_slow,
	output logic [31:0]        max_interval_ms
);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_gain    <= 16'd250;
			invert_current  <= 1'b0;
			min_valid_bus   <= 15'd800;
			alpha_fast      <= 17'd13107;
			alpha_slow      <= 17'd655;
			max_interval_ms <= 32'd60000;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CURRENT_GAIN:    current_gain    <= cfg_data[15:0];
				REG_INVERT_CURRENT:  invert_current  <= cfg_data[0];
				REG_MIN_VALID_BUS:   min_valid_bus   <= cfg_data[14:0];
				REG_ALPHA_FAST:      alpha_fast      <= cfg_data[16:0];
				REG_ALPHA_SLOW:      alpha_slow      <= cfg_data[16:0];
				REG_MAX_INTERVAL_MS: max_interval_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_assertions
// Port-level checks of the battery power statistics block.
// ----------------------------------------------------------------------------
module bps_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] charge_used,
	input logic [63:0] energy_used,
	input logic        stats_valid
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

	// never accepts a request while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while result pending");

	// totals only grow
	a_charge_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 charge_used >= $past(charge_used)) else $error("charge decreased");

	a_energy_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 energy_used >= $past(energy_used)) else $error("energy decreased");

	// once seeded, stays seeded
	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stats_valid |=> stats_valid) else $error("seed lost");

endmodule

bind battery_power_statistics bps_assertions u_bps_assertions (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.charge_used, .energy_used, .stats_valid
);
